@@ rtl/tun_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

   // width of each normal component on the result port
   localparam int OUT_BITS = 16;

   // control that travels with each item down the pipeline
   typedef struct packed {
      logic valid;
      logic degen;
   } ctl_type;

endpackage

`default_nettype wire

@@ rtl/tun_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Edge vectors, cross product, squared length and scaled squares.
// Five register stages, all advancing together on adv.
module tun_front #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 14
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire logic [COORD_BITS-1:0] p1_x,
   input  wire logic [COORD_BITS-1:0] p1_y,
   input  wire logic [COORD_BITS-1:0] p1_z,
   input  wire logic [COORD_BITS-1:0] p2_x,
   input  wire logic [COORD_BITS-1:0] p2_y,
   input  wire logic [COORD_BITS-1:0] p2_z,
   input  wire logic [COORD_BITS-1:0] p3_x,
   input  wire logic [COORD_BITS-1:0] p3_y,
   input  wire logic [COORD_BITS-1:0] p3_z,
   output tun_pkg::ctl_type           ctl_out,
   output logic [4*COORD_BITS+3:0]    len2_out,
   output logic [2*(2*COORD_BITS+1)+2*FRAC_BITS-1:0] rem_out [3],
   output logic [2:0]                 neg_out
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int CW = PW + 1;
   localparam int AW = 2 * COORD_BITS + 1;
   localparam int LW = 4 * COORD_BITS + 4;
   localparam int RW = 2 * AW + 2 * FRAC_BITS;

   logic [3:0]           vld_ff;
   logic signed [DW-1:0] u_ff [3];
   logic signed [DW-1:0] v_ff [3];
   logic signed [PW-1:0] pa_ff [3];
   logic signed [PW-1:0] pb_ff [3];
   logic [AW-1:0]        abs_ff [3];
   logic [2:0]           neg3_ff, neg4_ff, neg5_ff;
   logic [2*AW-1:0]      sq_ff [3];
   logic [LW-1:0]        len2_ff;
   logic [RW-1:0]        rem_ff [3];
   logic                 degen_ff, vld5_ff;

   logic signed [DW-1:0] u_in [3];
   logic signed [DW-1:0] v_in [3];
   logic signed [CW-1:0] cr_in [3];
   logic [LW-1:0]        len2_in;

   // edge vectors U = P2 - P1, V = P3 - P1
   always_comb begin
      u_in[0] = $signed({p2_x[COORD_BITS-1], p2_x}) - $signed({p1_x[COORD_BITS-1], p1_x});
      u_in[1] = $signed({p2_y[COORD_BITS-1], p2_y}) - $signed({p1_y[COORD_BITS-1], p1_y});
      u_in[2] = $signed({p2_z[COORD_BITS-1], p2_z}) - $signed({p1_z[COORD_BITS-1], p1_z});
      v_in[0] = $signed({p3_x[COORD_BITS-1], p3_x}) - $signed({p1_x[COORD_BITS-1], p1_x});
      v_in[1] = $signed({p3_y[COORD_BITS-1], p3_y}) - $signed({p1_y[COORD_BITS-1], p1_y});
      v_in[2] = $signed({p3_z[COORD_BITS-1], p3_z}) - $signed({p1_z[COORD_BITS-1], p1_z});
   end

   // cross product differences
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cr_in[k] = $signed({pa_ff[k][PW-1], pa_ff[k]}) - $signed({pb_ff[k][PW-1], pb_ff[k]});
      end
      len2_in = LW'(sq_ff[0]) + LW'(sq_ff[1]) + LW'(sq_ff[2]);
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         vld5_ff <= 1'b0;
      end else if (adv) begin
         vld_ff  <= {vld_ff[2:0], in_valid};
         vld5_ff <= vld_ff[3];
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff <= u_in;
         v_ff <= v_in;
         pa_ff[0] <= PW'(u_ff[1] * v_ff[2]);
         pb_ff[0] <= PW'(v_ff[1] * u_ff[2]);
         pa_ff[1] <= PW'(v_ff[0] * u_ff[2]);
         pb_ff[1] <= PW'(u_ff[0] * v_ff[2]);
         pa_ff[2] <= PW'(u_ff[0] * v_ff[1]);
         pb_ff[2] <= PW'(v_ff[0] * u_ff[1]);
         for (int k = 0; k < 3; k++) begin
            neg3_ff[k] <= cr_in[k][CW-1];
            abs_ff[k]  <= cr_in[k][CW-1] ? AW'(-cr_in[k]) : AW'(cr_in[k]);
            sq_ff[k]   <= abs_ff[k] * abs_ff[k];
            rem_ff[k]  <= RW'(sq_ff[k]) << (2 * FRAC_BITS);
         end
         neg4_ff  <= neg3_ff;
         neg5_ff  <= neg4_ff;
         len2_ff  <= len2_in;
         degen_ff <= (len2_in == '0);
      end
   end

   assign ctl_out  = '{valid: vld5_ff, degen: degen_ff};
   assign len2_out = len2_ff;
   assign rem_out  = rem_ff;
   assign neg_out  = neg5_ff;

endmodule

`default_nettype wire

@@ rtl/tun_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One bit of the magnitude search for all three components.
// Keeps rem = c^2*2^2F - m^2*L and ml = m*L, so a trial of bit BIT
// needs only shifts, two adds, one subtract and one compare.
module tun_cell #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 14,
   parameter int BIT        = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire tun_pkg::ctl_type     ctl_in,
   input  wire logic [4*COORD_BITS+3:0] len2_in,
   input  wire logic [2*(2*COORD_BITS+1)+2*FRAC_BITS-1:0] rem_in [3],
   input  wire logic [4*COORD_BITS+FRAC_BITS+4:0] ml_in [3],
   input  wire logic [FRAC_BITS:0]   m_in [3],
   input  wire logic [2:0]           neg_in,
   output tun_pkg::ctl_type          ctl_out,
   output logic [4*COORD_BITS+3:0]   len2_out,
   output logic [2*(2*COORD_BITS+1)+2*FRAC_BITS-1:0] rem_out [3],
   output logic [4*COORD_BITS+FRAC_BITS+4:0] ml_out [3],
   output logic [FRAC_BITS:0]        m_out [3],
   output logic [2:0]                neg_out
);

   localparam int LW  = 4 * COORD_BITS + 4;
   localparam int RW  = 2 * (2 * COORD_BITS + 1) + 2 * FRAC_BITS;
   localparam int MLW = LW + FRAC_BITS + 1;
   localparam int TW  = LW + 2 * FRAC_BITS + 3;

   tun_pkg::ctl_type   ctl_ff;
   logic [LW-1:0]      len2_ff;
   logic [RW-1:0]      rem_ff [3];
   logic [MLW-1:0]     ml_ff [3];
   logic [FRAC_BITS:0] m_ff [3];
   logic [2:0]         neg_ff;

   logic [TW-1:0]      term [3];
   logic               hit [3];
   logic [RW-1:0]      rem_nx [3];
   logic [MLW-1:0]     ml_nx [3];
   logic [FRAC_BITS:0] m_nx [3];

   // trial: (m + 2^b)^2 L - m^2 L = 2^(b+1) mL + 2^2b L
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term[k]   = (TW'(ml_in[k]) << (BIT + 1)) + (TW'(len2_in) << (2 * BIT));
         hit[k]    = TW'(rem_in[k]) >= term[k];
         rem_nx[k] = hit[k] ? RW'(TW'(rem_in[k]) - term[k]) : rem_in[k];
         ml_nx[k]  = hit[k] ? ml_in[k] + (MLW'(len2_in) << BIT) : ml_in[k];
         m_nx[k]   = m_in[k] | ((FRAC_BITS + 1)'(hit[k]) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len2_ff <= len2_in;
         rem_ff  <= rem_nx;
         ml_ff   <= ml_nx;
         m_ff    <= m_nx;
         neg_ff  <= neg_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign len2_out = len2_ff;
   assign rem_out  = rem_ff;
   assign ml_out   = ml_ff;
   assign m_out    = m_ff;
   assign neg_out  = neg_ff;

endmodule

`default_nettype wire

@@ rtl/triangle_unit_normal.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: five front stages, one search cell per result bit and an output register;
// one triangle per cycle while rsp_ready is high or no result is held, and all
// stages stall together when a valid result is held with rsp_ready low.
// Reset: synchronous, active high; clears all valid bits, pipeline is empty after.
module triangle_unit_normal #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 14
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [COORD_BITS-1:0] req_p1_x,
   input  wire logic [COORD_BITS-1:0] req_p1_y,
   input  wire logic [COORD_BITS-1:0] req_p1_z,
   input  wire logic [COORD_BITS-1:0] req_p2_x,
   input  wire logic [COORD_BITS-1:0] req_p2_y,
   input  wire logic [COORD_BITS-1:0] req_p2_z,
   input  wire logic [COORD_BITS-1:0] req_p3_x,
   input  wire logic [COORD_BITS-1:0] req_p3_y,
   input  wire logic [COORD_BITS-1:0] req_p3_z,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [tun_pkg::OUT_BITS-1:0] rsp_normal_x,
   output logic [tun_pkg::OUT_BITS-1:0] rsp_normal_y,
   output logic [tun_pkg::OUT_BITS-1:0] rsp_normal_z,
   output logic                       rsp_degenerate
);

   localparam int OB    = tun_pkg::OUT_BITS;
   localparam int LW    = 4 * COORD_BITS + 4;
   localparam int RW    = 2 * (2 * COORD_BITS + 1) + 2 * FRAC_BITS;
   localparam int MLW   = LW + FRAC_BITS + 1;
   localparam int MW    = FRAC_BITS + 1;
   localparam int EW    = MW + OB;
   localparam int NCELL = FRAC_BITS + 1;

   logic adv;

   tun_pkg::ctl_type ctl_c  [NCELL+1];
   logic [LW-1:0]    len2_c [NCELL+1];
   logic [RW-1:0]    rem_c  [NCELL+1][3];
   logic [MLW-1:0]   ml_c   [NCELL+1][3];
   logic [MW-1:0]    m_c    [NCELL+1][3];
   logic [2:0]       neg_c  [NCELL+1];

   logic          out_vld_ff, out_degen_ff;
   logic [OB-1:0] out_n_ff [3];
   logic [OB-1:0] out_n_in [3];
   logic [EW-1:0] ext;
   logic [OB-1:0] mag;

   // whole pipeline moves unless a finished result is held
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   tun_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .p1_x     (req_p1_x),
      .p1_y     (req_p1_y),
      .p1_z     (req_p1_z),
      .p2_x     (req_p2_x),
      .p2_y     (req_p2_y),
      .p2_z     (req_p2_z),
      .p3_x     (req_p3_x),
      .p3_y     (req_p3_y),
      .p3_z     (req_p3_z),
      .ctl_out  (ctl_c[0]),
      .len2_out (len2_c[0]),
      .rem_out  (rem_c[0]),
      .neg_out  (neg_c[0])
   );

   // search starts from m = 0
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ml_c[0][k] = '0;
         m_c[0][k]  = '0;
      end
   end

   // chain of search cells, most significant bit first
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      tun_cell #(
         .COORD_BITS (COORD_BITS),
         .FRAC_BITS  (FRAC_BITS),
         .BIT        (FRAC_BITS - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .ctl_in   (ctl_c[i]),
         .len2_in  (len2_c[i]),
         .rem_in   (rem_c[i]),
         .ml_in    (ml_c[i]),
         .m_in     (m_c[i]),
         .neg_in   (neg_c[i]),
         .ctl_out  (ctl_c[i+1]),
         .len2_out (len2_c[i+1]),
         .rem_out  (rem_c[i+1]),
         .ml_out   (ml_c[i+1]),
         .m_out    (m_c[i+1]),
         .neg_out  (neg_c[i+1])
      );
   end

   // saturate, apply sign, zero a degenerate normal
   always_comb begin
      ext = '0;
      mag = '0;
      for (int k = 0; k < 3; k++) begin
         ext = EW'(m_c[NCELL][k]);
         mag = (ext > EW'((1 << (OB - 1)) - 1)) ? OB'((1 << (OB - 1)) - 1) : OB'(ext);
         if (ctl_c[NCELL].degen) begin
            out_n_in[k] = '0;
         end else if (neg_c[NCELL][k]) begin
            out_n_in[k] = -mag;
         end else begin
            out_n_in[k] = mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= ctl_c[NCELL].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_n_ff     <= out_n_in;
         out_degen_ff <= ctl_c[NCELL].degen;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_normal_x   = out_n_ff[0];
   assign rsp_normal_y   = out_n_ff[1];
   assign rsp_normal_z   = out_n_ff[2];
   assign rsp_degenerate = out_degen_ff;

endmodule

`default_nettype wire
